FILE: src/y420fs_pkg.sv
// ----------------------------------------------------------------------------
// y420fs_pkg
// Shared widths, defaults, codes and Q16 color coefficients of the 4:2:0
// frame store with YCbCr to RGB readout.
// ----------------------------------------------------------------------------
package y420fs_pkg;

  // Default geometry
  localparam int FRAME_DIM_DEF  = 512;
  localparam int NUM_FRAMES_DEF = 3;

  // Field widths of one transaction
  localparam int FRAME_W  = 2;
  localparam int BLOCK_W  = 3;
  localparam int MB_W     = 5;
  localparam int SPOS_W   = 3;
  localparam int SAMPLE_W = 16;
  localparam int PIX_W    = 9;
  localparam int BYTE_W   = 8;

  // Transaction kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Block codes
  localparam logic [BLOCK_W-1:0] BLK_CB = 3'd4;
  localparam logic [BLOCK_W-1:0] BLK_CR = 3'd5;

  // Q16 JFIF coefficients
  localparam int COEF_W = 18;
  localparam logic signed [COEF_W-1:0] K_CB_B = 18'sd116130;
  localparam logic signed [COEF_W-1:0] K_CB_G = 18'sd22554;
  localparam logic signed [COEF_W-1:0] K_CR_G = 18'sd46802;
  localparam logic signed [COEF_W-1:0] K_CR_R = 18'sd91881;

  // Chroma offset and arithmetic widths
  localparam int CHR_W  = SAMPLE_W + 1;
  localparam logic signed [CHR_W-1:0] CHROMA_OFS = 17'sd128;
  localparam int PROD_W = COEF_W + CHR_W;
  localparam int ACC_W  = PROD_W + 1;

endpackage

FILE: src/yuv420_frame_store_to_rgb.sv
// ----------------------------------------------------------------------------
// yuv420_frame_store_to_rgb
// Multi-picture 4:2:0 frame store with JFIF YCbCr to RGB pixel readout.
// ----------------------------------------------------------------------------
// A write transaction (kind 0) stores one decoded sample: blocks 0..3 are the
// luma quadrants of a 16x16 macroblock, blocks 4 and 5 the Cb and Cr blocks
// at half resolution. A read transaction (kind 1) returns B, G and R of one
// pixel, with chroma taken at (row/2, col/2), offset by 128, and converted
// with the JFIF coefficients in Q16, truncated and clamped to 0..255. Writes
// with block id 6 or 7, a frame beyond NUM_FRAMES or a position outside the
// plane are dropped; a read of such a position uses zero for that sample.
// The block handles one transaction at a time. A luma write runs ROW, ADDR
// and ACCESS, a chroma write also DATA (read-modify-write of the packed
// Cb/Cr word on the single port of the chroma memory), a read also DATA and
// SUM, where it holds while the output register is full and stalled; the
// address sequencer (row index, then full address) and the registered
// memory read set these steps. A new transaction is taken while a finished
// result still waits in the output register. The memories come up undefined
// and need no clearing pass; an unwritten sample reads as an undefined color.
// ----------------------------------------------------------------------------
module yuv420_frame_store_to_rgb #(
  parameter int FRAME_DIM  = y420fs_pkg::FRAME_DIM_DEF,
  parameter int NUM_FRAMES = y420fs_pkg::NUM_FRAMES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  kind_i,
  input  logic        [y420fs_pkg::FRAME_W-1:0]  frame_i,
  input  logic        [y420fs_pkg::BLOCK_W-1:0]  block_id_i,
  input  logic        [y420fs_pkg::MB_W-1:0]     mb_row_i,
  input  logic        [y420fs_pkg::MB_W-1:0]     mb_col_i,
  input  logic        [y420fs_pkg::SPOS_W-1:0]   sample_row_i,
  input  logic        [y420fs_pkg::SPOS_W-1:0]   sample_col_i,
  input  logic signed [y420fs_pkg::SAMPLE_W-1:0] sample_i,
  input  logic        [y420fs_pkg::PIX_W-1:0]    pixel_row_i,
  input  logic        [y420fs_pkg::PIX_W-1:0]    pixel_col_i,
  // output channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic        [y420fs_pkg::BYTE_W-1:0]   blue_o,
  output logic        [y420fs_pkg::BYTE_W-1:0]   green_o,
  output logic        [y420fs_pkg::BYTE_W-1:0]   red_o
);

  import y420fs_pkg::*;

  // Geometry. Luma is one 16-bit word per pixel; chroma is one 32-bit word
  // per half-resolution site holding {Cr, Cb}.
  localparam int HALF_DIM   = FRAME_DIM / 2;
  localparam int LUMA_DEPTH = NUM_FRAMES * FRAME_DIM * FRAME_DIM;
  localparam int CHR_DEPTH  = NUM_FRAMES * HALF_DIM * HALF_DIM;
  localparam int LROW_W     = $clog2(NUM_FRAMES * FRAME_DIM);
  localparam int CROW_W     = $clog2(NUM_FRAMES * HALF_DIM);
  localparam int LA_W       = $clog2(LUMA_DEPTH);
  localparam int CA_W       = $clog2(CHR_DEPTH);
  localparam int CWORD_W    = 2 * SAMPLE_W;

  // Sequencer
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ROW    = 6'b000010,
    ST_ADDR   = 6'b000100,
    ST_ACCESS = 6'b001000,
    ST_DATA   = 6'b010000,
    ST_SUM    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic in_acc;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Captured transaction
  // --------------------------------------------------------------------------
  logic                       kind_q;
  logic        [FRAME_W-1:0]  frame_q;
  logic        [BLOCK_W-1:0]  block_q;
  logic        [MB_W-1:0]     mb_row_q, mb_col_q;
  logic        [SPOS_W-1:0]   srow_q, scol_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic        [PIX_W-1:0]    prow_q, pcol_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q   <= kind_i;
      frame_q  <= frame_i;
      block_q  <= block_id_i;
      mb_row_q <= mb_row_i;
      mb_col_q <= mb_col_i;
      srow_q   <= sample_row_i;
      scol_q   <= sample_col_i;
      sample_q <= sample_i;
      prow_q   <= pixel_row_i;
      pcol_q   <= pixel_col_i;
    end
  end

  // --------------------------------------------------------------------------
  // ROW step: plane positions, range checks, frame row index
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0]  lrow, lcol, crow, ccol;
  logic              frame_ok, blk_luma, blk_chroma;
  logic              luma_ok_d, chroma_ok_d;
  logic [LROW_W-1:0] lidx_d;
  logic [CROW_W-1:0] cidx_d;

  always_comb begin
    if (kind_q == KIND_WRITE) begin
      // luma: mb*16 + quadrant*8 + sample, chroma: mb*8 + sample
      lrow = {mb_row_q, block_q[1], srow_q};
      lcol = {mb_col_q, block_q[0], scol_q};
      crow = {1'b0, mb_row_q, srow_q};
      ccol = {1'b0, mb_col_q, scol_q};
    end else begin
      lrow = prow_q;
      lcol = pcol_q;
      crow = {1'b0, prow_q[PIX_W-1:1]};
      ccol = {1'b0, pcol_q[PIX_W-1:1]};
    end
    frame_ok   = 32'(frame_q) < 32'(NUM_FRAMES);
    blk_luma   = !block_q[BLOCK_W-1];
    blk_chroma = (block_q == BLK_CB) || (block_q == BLK_CR);
    luma_ok_d  = frame_ok && (32'(lrow) < 32'(FRAME_DIM))
                 && (32'(lcol) < 32'(FRAME_DIM))
                 && ((kind_q == KIND_READ) || blk_luma);
    chroma_ok_d = frame_ok && (32'(crow) < 32'(HALF_DIM))
                  && (32'(ccol) < 32'(HALF_DIM))
                  && ((kind_q == KIND_READ) || blk_chroma);
    lidx_d = LROW_W'(32'(frame_q) * 32'(FRAME_DIM) + 32'(lrow));
    cidx_d = CROW_W'(32'(frame_q) * 32'(HALF_DIM) + 32'(crow));
  end

  logic              luma_ok_q, chroma_ok_q;
  logic [LROW_W-1:0] lidx_q;
  logic [CROW_W-1:0] cidx_q;
  logic [PIX_W-1:0]  lcol_q, ccol_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROW) begin
      luma_ok_q   <= luma_ok_d;
      chroma_ok_q <= chroma_ok_d;
      lidx_q      <= lidx_d;
      cidx_q      <= cidx_d;
      lcol_q      <= lcol;
      ccol_q      <= ccol;
    end
  end

  // --------------------------------------------------------------------------
  // ADDR step: word addresses
  // --------------------------------------------------------------------------
  logic [LA_W-1:0] laddr_q;
  logic [CA_W-1:0] caddr_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ADDR) begin
      laddr_q <= LA_W'(32'(lidx_q) * 32'(FRAME_DIM) + 32'(lcol_q));
      caddr_q <= CA_W'(32'(cidx_q) * 32'(HALF_DIM) + 32'(ccol_q));
    end
  end

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  logic                luma_en, luma_we, chroma_en, chroma_we;
  logic [SAMPLE_W-1:0] luma_rdata;
  logic [CWORD_W-1:0]  chroma_rdata, chroma_wdata;

  // luma write in ACCESS; chroma write is the second half of a
  // read-modify-write, only one transaction is in flight so no overlap
  assign luma_en   = (state_q == ST_ACCESS);
  assign luma_we   = (state_q == ST_ACCESS) && (kind_q == KIND_WRITE) && luma_ok_q;
  assign chroma_en = (state_q == ST_ACCESS);
  assign chroma_we = (state_q == ST_DATA) && (kind_q == KIND_WRITE) && chroma_ok_q;

  assign chroma_wdata = (block_q == BLK_CR) ?
                        {sample_q, chroma_rdata[SAMPLE_W-1:0]} :
                        {chroma_rdata[CWORD_W-1:SAMPLE_W], sample_q};

  y420fs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (LUMA_DEPTH)
  ) u_luma_ram (
    .clk_i   (clk_i),
    .en_i    (luma_en),
    .we_i    (luma_we),
    .addr_i  (laddr_q),
    .wdata_i (sample_q),
    .rdata_o (luma_rdata)
  );

  y420fs_ram #(
    .WIDTH (CWORD_W),
    .DEPTH (CHR_DEPTH)
  ) u_chroma_ram (
    .clk_i   (clk_i),
    .en_i    (chroma_en),
    .we_i    (chroma_we),
    .addr_i  (caddr_q),
    .wdata_i (chroma_wdata),
    .rdata_o (chroma_rdata)
  );

  // --------------------------------------------------------------------------
  // DATA step (reads): zero out-of-range samples, offset chroma, multiply
  // --------------------------------------------------------------------------
  logic        [SAMPLE_W-1:0] y_raw, cb_raw, cr_raw;
  logic signed [CHR_W-1:0]    cb_s, cr_s;
  logic signed [SAMPLE_W-1:0] y_q;
  logic signed [PROD_W-1:0]   prod_b_q, prod_gb_q, prod_gr_q, prod_r_q;

  always_comb begin
    y_raw  = luma_ok_q   ? luma_rdata : '0;
    cb_raw = chroma_ok_q ? chroma_rdata[SAMPLE_W-1:0] : '0;
    cr_raw = chroma_ok_q ? chroma_rdata[CWORD_W-1:SAMPLE_W] : '0;
    cb_s   = signed'({cb_raw[SAMPLE_W-1], cb_raw}) - CHROMA_OFS;
    cr_s   = signed'({cr_raw[SAMPLE_W-1], cr_raw}) - CHROMA_OFS;
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DATA) && (kind_q == KIND_READ)) begin
      y_q       <= signed'(y_raw);
      prod_b_q  <= PROD_W'(K_CB_B) * PROD_W'(cb_s);
      prod_gb_q <= PROD_W'(K_CB_G) * PROD_W'(cb_s);
      prod_gr_q <= PROD_W'(K_CR_G) * PROD_W'(cr_s);
      prod_r_q  <= PROD_W'(K_CR_R) * PROD_W'(cr_s);
    end
  end

  // --------------------------------------------------------------------------
  // SUM step: Q16 sums, truncate, clamp
  // --------------------------------------------------------------------------
  function automatic logic [BYTE_W-1:0] clamp_byte(input logic [ACC_W-1:0] acc);
    logic [BYTE_W-1:0] res;
    if (acc[ACC_W-1]) begin
      res = '0;                       // negative, truncation gives <= 0
    end else if (|acc[ACC_W-2:24]) begin
      res = '1;
    end else begin
      res = acc[23:16];
    end
    return res;
  endfunction

  logic [ACC_W-1:0] ys_ext, acc_b, acc_g, acc_r;

  always_comb begin
    ys_ext = {{(ACC_W-SAMPLE_W-16){y_q[SAMPLE_W-1]}}, y_q, 16'h0000};
    acc_b  = ys_ext + {prod_b_q[PROD_W-1], prod_b_q};
    acc_g  = ys_ext - {prod_gb_q[PROD_W-1], prod_gb_q}
                    - {prod_gr_q[PROD_W-1], prod_gr_q};
    acc_r  = ys_ext + {prod_r_q[PROD_W-1], prod_r_q};
  end

  // Output register
  logic              out_valid_q, out_free, out_load;
  logic [BYTE_W-1:0] blue_q, green_q, red_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == ST_SUM) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      blue_q  <= clamp_byte(acc_b);
      green_q <= clamp_byte(acc_g);
      red_q   <= clamp_byte(acc_r);
    end
  end

  assign out_valid_o = out_valid_q;
  assign blue_o      = blue_q;
  assign green_o     = green_q;
  assign red_o       = red_q;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_ROW;
      end
      ST_ROW:  state_d = ST_ADDR;
      ST_ADDR: state_d = ST_ACCESS;
      ST_ACCESS: begin
        if ((kind_q == KIND_READ) || chroma_ok_q) state_d = ST_DATA;
        else                                      state_d = ST_IDLE;
      end
      ST_DATA: begin
        if (kind_q == KIND_READ) state_d = ST_SUM;
        else                     state_d = ST_IDLE;
      end
      ST_SUM: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  // a read reaches the sum step after acceptance, through ROW, ADDR, ACCESS and DATA
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (kind_i == KIND_READ)) |-> ##5 (state_q == ST_SUM))
    else $error("read transaction did not reach the sum step in time");

  // pixel reads never modify either memory
  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (luma_we || chroma_we) |-> (kind_q == KIND_WRITE))
    else $error("memory write during a read transaction");

  // chroma write always follows its own read of the packed word
  a_chroma_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chroma_we |-> $past(chroma_en && !chroma_we))
    else $error("chroma write without preceding read");

  // only read transactions produce a result
  a_sum_only_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (kind_q == KIND_READ))
    else $error("write transaction in the sum step");
`endif

endmodule

FILE: src/y420fs_ram.sv
// ----------------------------------------------------------------------------
// y420fs_ram
// Generic single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module y420fs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else if (en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: verif/yuv420_frame_store_to_rgb_test.sv
// ----------------------------------------------------------------------------
// yuv420_frame_store_to_rgb_test
// Self-checking bench for the 4:2:0 frame store with YCbCr to RGB readout.
// Sample writes and pixel reads go in on a valid/stall channel. A scoreboard
// keeps its own copy of the written luma and chroma samples, converts every
// accepted read with Q16 JFIF arithmetic and compares each returned color
// against the oldest outstanding prediction. A pixel is read only once its
// luma and both chroma samples have been written, or else in the frame
// beyond the last buffer, which reads as all zero.
// ----------------------------------------------------------------------------
module yuv420_frame_store_to_rgb_test;
  import y420fs_pkg::*;

  localparam int DIM     = FRAME_DIM_DEF;
  localparam int HDIM    = FRAME_DIM_DEF / 2;
  localparam int NFRAMES = NUM_FRAMES_DEF;

  // Q16 conversion factors, kept apart from the block's own copies
  localparam longint Q16_BLUE_CB  = 116130;
  localparam longint Q16_GREEN_CB = 22554;
  localparam longint Q16_GREEN_CR = 46802;
  localparam longint Q16_RED_CR   = 91881;
  localparam longint Q16_ONE      = 65536;
  localparam longint CHROMA_BIAS  = 128;

  localparam int REPORT_MAX   = 10;
  localparam int RANDOM_ITEMS = 1250;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic                kind;
    logic [FRAME_W-1:0]  frame;
    logic [BLOCK_W-1:0]  block_id;
    logic [MB_W-1:0]     mb_row;
    logic [MB_W-1:0]     mb_col;
    logic [SPOS_W-1:0]   sample_row;
    logic [SPOS_W-1:0]   sample_col;
    logic [SAMPLE_W-1:0] sample_val;
    logic [PIX_W-1:0]    pixel_row;
    logic [PIX_W-1:0]    pixel_col;
  } xact_t;

  typedef struct packed {
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
  } rgb_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirror of the sample stores plus the color conversion.
  // --------------------------------------------------------------------------
  class rgb_scoreboard;
    logic signed [SAMPLE_W-1:0] luma_mem [int];
    logic signed [SAMPLE_W-1:0] cb_mem   [int];
    logic signed [SAMPLE_W-1:0] cr_mem   [int];
    rgb_t pending_rgb [$];
    int   errors;

    function automatic logic [BYTE_W-1:0] clamp_byte(longint acc);
      longint v;
      v = acc / Q16_ONE;          // truncates toward zero
      if (v < 0) return '0;
      if (v > 255) return 8'd255;
      return v[BYTE_W-1:0];
    endfunction

    function automatic rgb_t ycc_to_rgb(int f, int r, int c);
      longint y, cb, cr, ys;
      int     hkey;
      rgb_t   px;
      y  = 0;
      cb = 0;
      cr = 0;
      hkey = (f * HDIM + r / 2) * HDIM + c / 2;
      if (f < NFRAMES) begin
        if (luma_mem.exists((f * DIM + r) * DIM + c)) y = luma_mem[(f * DIM + r) * DIM + c];
        if (cb_mem.exists(hkey)) cb = cb_mem[hkey];
        if (cr_mem.exists(hkey)) cr = cr_mem[hkey];
      end
      cb = cb - CHROMA_BIAS;
      cr = cr - CHROMA_BIAS;
      ys = y * Q16_ONE;
      px.blue  = clamp_byte(ys + Q16_BLUE_CB * cb);
      px.green = clamp_byte(ys - Q16_GREEN_CB * cb - Q16_GREEN_CR * cr);
      px.red   = clamp_byte(ys + Q16_RED_CR * cr);
      return px;
    endfunction

    // Called for every accepted input transaction, in acceptance order.
    function void note_input(xact_t x);
      int r, c;
      if (x.kind == KIND_READ) begin
        pending_rgb.push_back(ycc_to_rgb(x.frame, x.pixel_row, x.pixel_col));
        return;
      end
      if (x.frame >= NFRAMES || x.block_id > BLK_CR) return;
      if (x.block_id < BLK_CB) begin
        r = x.mb_row * 16 + x.block_id[1] * 8 + x.sample_row;
        c = x.mb_col * 16 + x.block_id[0] * 8 + x.sample_col;
        if (r < DIM && c < DIM) luma_mem[(x.frame * DIM + r) * DIM + c] = x.sample_val;
      end else begin
        r = x.mb_row * 8 + x.sample_row;
        c = x.mb_col * 8 + x.sample_col;
        if (r < HDIM && c < HDIM) begin
          if (x.block_id == BLK_CB) cb_mem[(x.frame * HDIM + r) * HDIM + c] = x.sample_val;
          else cr_mem[(x.frame * HDIM + r) * HDIM + c] = x.sample_val;
        end
      end
    endfunction

    function void check_result(rgb_t got);
      rgb_t want;
      if (pending_rgb.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected pixel B=%0d G=%0d R=%0d", got.blue, got.green, got.red);
        return;
      end
      want = pending_rgb.pop_front();
      if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("pixel mismatch: expected B=%0d G=%0d R=%0d, got B=%0d G=%0d R=%0d",
                   want.blue, want.green, want.red, got.blue, got.green, got.red);
      end
    endfunction

    function int pending_count();
      return pending_rgb.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst_ni;
  logic                in_valid;
  logic                in_stall;
  logic                kind;
  logic [FRAME_W-1:0]  frame;
  logic [BLOCK_W-1:0]  block_id;
  logic [MB_W-1:0]     mb_row;
  logic [MB_W-1:0]     mb_col;
  logic [SPOS_W-1:0]   sample_row;
  logic [SPOS_W-1:0]   sample_col;
  logic [SAMPLE_W-1:0] sample_val;
  logic [PIX_W-1:0]    pixel_row;
  logic [PIX_W-1:0]    pixel_col;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [BYTE_W-1:0]   blue;
  logic [BYTE_W-1:0]   green;
  logic [BYTE_W-1:0]   red;

  yuv420_frame_store_to_rgb #(
    .FRAME_DIM (DIM),
    .NUM_FRAMES(NFRAMES)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .kind_i      (kind),
    .frame_i     (frame),
    .block_id_i  (block_id),
    .mb_row_i    (mb_row),
    .mb_col_i    (mb_col),
    .sample_row_i(sample_row),
    .sample_col_i(sample_col),
    .sample_i    (sample_val),
    .pixel_row_i (pixel_row),
    .pixel_col_i (pixel_col),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .blue_o      (blue),
    .green_o     (green),
    .red_o       (red)
  );

  rgb_scoreboard sb;
  int            burst_left;
  int            n_sent;
  int            known_px [$];   // packed frame/row/col of fully written pixels
  int            stall_mode = 0;
  int            cyc = 0;

  always #10 clk = ~clk;

  // Receiver: stall behavior is redrawn at random between never, light,
  // heavy and a periodic on/off pattern.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 256 == 0) stall_mode <= $urandom_range(0, 3);
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= cyc[2];
      endcase
    end
  end

  // Result monitor: a transaction completes at an edge with valid and no stall.
  always @(posedge clk) begin
    if (rst_ni && out_valid === 1'b1 && out_stall == 1'b0) sb.check_result('{blue, green, red});
  end

  // Every field random; the callers then pin down what matters.
  function automatic xact_t rand_xact();
    xact_t x;
    x.kind       = 1'($urandom);
    x.frame      = FRAME_W'($urandom);
    x.block_id   = BLOCK_W'($urandom);
    x.mb_row     = MB_W'($urandom);
    x.mb_col     = MB_W'($urandom);
    x.sample_row = SPOS_W'($urandom);
    x.sample_col = SPOS_W'($urandom);
    x.sample_val = SAMPLE_W'($urandom);
    x.pixel_row  = PIX_W'($urandom);
    x.pixel_col  = PIX_W'($urandom);
    return x;
  endfunction

  // Mostly in-range video levels, some near the clamp edges, some anything.
  function automatic int rand_level();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 255);
      6, 7:             return int'($urandom_range(0, 1100)) - 400;
      8:                return $urandom_range(0, 1) ? 32767 : -32768;
      default:          return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Sender: bursts of random length, random gaps between them. The payload
  // only changes after the transaction has been taken.
  task automatic drive_xact(input xact_t x);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 16);
    end
    kind       <= x.kind;
    frame      <= x.frame;
    block_id   <= x.block_id;
    mb_row     <= x.mb_row;
    mb_col     <= x.mb_col;
    sample_row <= x.sample_row;
    sample_col <= x.sample_col;
    sample_val <= x.sample_val;
    pixel_row  <= x.pixel_row;
    pixel_col  <= x.pixel_col;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_input(x);
    burst_left--;
    n_sent++;
  endtask

  // Luma sample at plane position (r, c): quadrant from bit 3 of each.
  task automatic put_luma(input int f, input int r, input int c, input int v);
    xact_t x;
    x            = rand_xact();
    x.kind       = KIND_WRITE;
    x.frame      = FRAME_W'(f);
    x.block_id   = BLOCK_W'(((r / 8) % 2) * 2 + (c / 8) % 2);
    x.mb_row     = MB_W'(r / 16);
    x.mb_col     = MB_W'(c / 16);
    x.sample_row = SPOS_W'(r % 8);
    x.sample_col = SPOS_W'(c % 8);
    x.sample_val = SAMPLE_W'(v);
    drive_xact(x);
  endtask

  task automatic put_chroma(input int f, input bit is_cr, input int r, input int c, input int v);
    xact_t x;
    x            = rand_xact();
    x.kind       = KIND_WRITE;
    x.frame      = FRAME_W'(f);
    x.block_id   = is_cr ? BLK_CR : BLK_CB;
    x.mb_row     = MB_W'(r / 8);
    x.mb_col     = MB_W'(c / 8);
    x.sample_row = SPOS_W'(r % 8);
    x.sample_col = SPOS_W'(c % 8);
    x.sample_val = SAMPLE_W'(v);
    drive_xact(x);
  endtask

  task automatic get_pixel(input int f, input int r, input int c);
    xact_t x;
    x           = rand_xact();
    x.kind      = KIND_READ;
    x.frame     = FRAME_W'(f);
    x.pixel_row = PIX_W'(r);
    x.pixel_col = PIX_W'(c);
    drive_xact(x);
  endtask

  task automatic read_known();
    int key;
    key = known_px[$urandom_range(0, known_px.size() - 1)];
    get_pixel(key / (DIM * DIM), (key / DIM) % DIM, key % DIM);
  endtask

  // One chroma site in a valid frame: both chroma samples, one to four of
  // the luma pixels that share them, then reads of those pixels and of up to two known ones.
  task automatic pixel_group();
    int f, hr, hc, nl;
    int pr [4];
    int pc [4];
    f = $urandom_range(0, NFRAMES - 1);
    // A few sites reused so that overwrites get read back too.
    if ($urandom_range(0, 4) == 0) begin
      hr = $urandom_range(0, 1);
      hc = $urandom_range(0, 1);
    end else begin
      hr = $urandom_range(0, HDIM - 1);
      hc = $urandom_range(0, HDIM - 1);
    end
    if ($urandom_range(0, 1)) begin
      put_chroma(f, 1'b0, hr, hc, rand_level());
      put_chroma(f, 1'b1, hr, hc, rand_level());
    end else begin
      put_chroma(f, 1'b1, hr, hc, rand_level());
      put_chroma(f, 1'b0, hr, hc, rand_level());
    end
    nl = $urandom_range(1, 4);
    for (int i = 0; i < nl; i++) begin
      pr[i] = 2 * hr + i / 2;
      pc[i] = 2 * hc + i % 2;
      put_luma(f, pr[i], pc[i], rand_level());
      known_px.push_back((f * DIM + pr[i]) * DIM + pc[i]);
    end
    for (int i = 0; i < nl; i++) get_pixel(f, pr[i], pc[i]);
    repeat ($urandom_range(0, 2)) read_known();
  endtask

  // Stray traffic: arbitrary writes (some ignored, some half-finished
  // groups) and reads of the frame beyond the last buffer.
  task automatic stray_traffic();
    xact_t x;
    x = rand_xact();
    if (x.kind == KIND_READ) x.frame = FRAME_W'(NFRAMES);
    drive_xact(x);
  endtask

  // Timeout guard
  initial begin
    #6000000;
    $display("yuv420_frame_store_to_rgb_test failed");
    $finish;
  end

  initial begin
    xact_t x;
    int    pick;
    sb         = new();
    burst_left = 0;
    n_sent     = 0;
    rst_ni     <= 1'b0;
    in_valid   <= 1'b0;
    kind       <= KIND_WRITE;
    frame      <= '0;
    block_id   <= '0;
    mb_row     <= '0;
    mb_col     <= '0;
    sample_row <= '0;
    sample_col <= '0;
    sample_val <= '0;
    pixel_row  <= '0;
    pixel_col  <= '0;
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // Frame beyond the last buffer: all samples read as zero.
    get_pixel(NFRAMES, 0, 0);
    get_pixel(NFRAMES, DIM - 1, DIM - 1);
    // Neutral gray at the top-left corner of frame 0.
    put_chroma(0, 1'b0, 0, 0, 128);
    put_chroma(0, 1'b1, 0, 0, 128);
    put_luma(0, 0, 0, 128);
    get_pixel(0, 0, 0);
    // Luma extremes sharing that chroma site: clamp low and high.
    put_luma(0, 0, 1, -32768);
    put_luma(0, 1, 1, 32767);
    get_pixel(0, 0, 1);
    get_pixel(0, 1, 1);
    // Bottom-right corner of the last frame, chroma at its extremes.
    put_chroma(NFRAMES - 1, 1'b0, HDIM - 1, HDIM - 1, 32767);
    put_chroma(NFRAMES - 1, 1'b1, HDIM - 1, HDIM - 1, -32768);
    put_luma(NFRAMES - 1, DIM - 1, DIM - 1, 255);
    put_luma(NFRAMES - 1, DIM - 2, DIM - 2, 0);
    get_pixel(NFRAMES - 1, DIM - 1, DIM - 1);
    get_pixel(NFRAMES - 1, DIM - 2, DIM - 2);
    // Ignored writes: frame beyond the buffers, block ids six and seven.
    x            = rand_xact();
    x.kind       = KIND_WRITE;
    x.frame      = FRAME_W'(NFRAMES);
    drive_xact(x);
    x.frame      = '0;
    x.block_id   = BLOCK_W'(BLK_CR + 1);
    drive_xact(x);
    x.block_id   = BLOCK_W'(BLK_CR + 2);
    drive_xact(x);
    // Overwrite and read back.
    put_luma(0, 0, 0, 0);
    get_pixel(0, 0, 0);
    known_px.push_back(0);
    known_px.push_back(1);
    known_px.push_back(DIM + 1);
    known_px.push_back(((NFRAMES - 1) * DIM + DIM - 1) * DIM + DIM - 1);

    // ---- random part ----
    while (n_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) pixel_group();
      else if (pick < 85) repeat ($urandom_range(1, 4)) read_known();
      else if (pick < 92) put_chroma($urandom_range(0, NFRAMES - 1), 1'($urandom),
                                     $urandom_range(0, HDIM - 1), $urandom_range(0, HDIM - 1),
                                     rand_level());
      else stray_traffic();
    end
    in_valid <= 1'b0;

    // Drain: every predicted pixel back, then a few quiet cycles to catch
    // anything extra.
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("yuv420_frame_store_to_rgb_test passed");
    end else begin
      $display("yuv420_frame_store_to_rgb_test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/y420fs_pkg.sv
src/y420fs_ram.sv
src/yuv420_frame_store_to_rgb.sv
verif/yuv420_frame_store_to_rgb_test.sv
